### sv/biased_field_bit_packer_assert.svh
// assertion macros for the biased field bit packer
// used by the top level only, no other dependencies
`ifndef BIASED_FIELD_BIT_PACKER_ASSERT_SVH
`define BIASED_FIELD_BIT_PACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define BFBP_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("bfbp assertion failed");
`define BFBP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bfbp assertion failed");
`else
`define BFBP_ASSERT_ALWAYS(lbl, expr)
`define BFBP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/bfbp_pkg.sv
// shared types and constants of the biased field bit packer
// no dependencies
package bfbp_pkg;

   localparam int BYTE_BITS  = 8;
   localparam int WID_W      = 7;
   localparam int SUM_W      = 33;
   localparam int FULL_W     = 64;
   localparam int QDEPTH     = 2;
   localparam int QCOUNT_W   = 2;

   typedef struct packed {
      logic [WID_W-1:0] wid;
      logic             flush;
   } item_ctrl_type;

   typedef struct packed {
      logic load;
      logic emit;
      logic emit_last;
      logic busy;
      logic flushing;
      logic leftover_empty;
   } back_status_type;

endpackage

### sv/biased_field_bit_packer.sv
// biased field bit packer, top level
// depends on bfbp_pkg, bfbp_front, bfbp_queue, bfbp_back
//
// req channel: one field per item (value, bias, width, end_marker,
// end_of_block). value + bias is formed exactly, sign extended and its low
// width bits (saturated to MAX_FIELD_WIDTH) are packed lsb first; an end
// marker packs all ones. end_of_block flushes the part byte zero padded and
// sets rsp_last on the final byte of that item.
// rsp channel: the packed bytes, with rsp_last.
// Each item passes through the two entry queue, is merged into the leftover
// bits by the back end and leaves byte by byte through the output byte
// register. The back end loads an item, then sends its full bytes; on
// end_of_block it ends with a flush step for the part byte, taken even when
// no bit is left, unless the last full byte closes the block.
// One byte at a time leaves through the single output byte register.
// Reset clears the leftover bits, the queue and the output valid flag.
// While rsp_stall is high and a byte is held, that byte is kept, the back end
// sends no new byte and the queue fills; req_stall rises when the queue is full.
`include "biased_field_bit_packer_assert.svh"
module biased_field_bit_packer import bfbp_pkg::*; #(
   parameter int MAX_FIELD_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_value,
   input  logic signed [31:0]   req_bias,
   input  logic [WID_W-1:0]     req_width,
   input  logic                 req_end_marker,
   input  logic                 req_end_of_block,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_BITS-1:0] rsp_out_byte,
   output logic                 rsp_last
);

   logic [MAX_FIELD_WIDTH-1:0] item_data, pop_data;
   item_ctrl_type              item_ctrl, pop_ctrl;
   logic                       q_full, q_valid, q_pop;
   logic [QCOUNT_W-1:0]        q_count;
   back_status_type            status;

   bfbp_front #(.MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)) u_front (
      .req_value        (req_value),
      .req_bias         (req_bias),
      .req_width        (req_width),
      .req_end_marker   (req_end_marker),
      .req_end_of_block (req_end_of_block),
      .item_data        (item_data),
      .item_ctrl        (item_ctrl)
   );

   bfbp_queue #(.MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (item_data),
      .push_ctrl (item_ctrl),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_data  (pop_data),
      .pop_ctrl  (pop_ctrl),
      .pop       (q_pop),
      .count     (q_count)
   );

   bfbp_back #(.MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (pop_data),
      .q_ctrl       (pop_ctrl),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .status       (status)
   );

   assign req_stall = q_full;

   `BFBP_ASSERT_ALWAYS(a_queue_bound, q_count <= QCOUNT_W'(QDEPTH))
   `BFBP_ASSERT_ALWAYS(a_load_or_emit, !(status.load && status.emit))
   `BFBP_ASSERT_NEXT(a_last_clears, status.emit_last, status.leftover_empty && !status.flushing)
   `BFBP_ASSERT_NEXT(a_last_shown, status.emit_last, rsp_valid && rsp_last)

endmodule

### sv/bfbp_front.sv
// front end: forms the biased field, saturates and masks the width
// depends on bfbp_pkg
module bfbp_front import bfbp_pkg::*; #(
   parameter int MAX_FIELD_WIDTH = 64
) (
   input  logic signed [31:0]          req_value,
   input  logic signed [31:0]          req_bias,
   input  logic [WID_W-1:0]            req_width,
   input  logic                        req_end_marker,
   input  logic                        req_end_of_block,
   output logic [MAX_FIELD_WIDTH-1:0]  item_data,
   output item_ctrl_type               item_ctrl
);

   localparam logic [WID_W-1:0] MAX_WID = WID_W'(MAX_FIELD_WIDTH);

   logic [SUM_W-1:0]           sum;
   logic [FULL_W-1:0]          full;
   logic [WID_W-1:0]           wid_sat;
   logic [MAX_FIELD_WIDTH-1:0] mask;
   logic [MAX_FIELD_WIDTH-1:0] field;

   always_comb begin
      sum     = {req_value[31], req_value} + {req_bias[31], req_bias};
      full    = {{(FULL_W-SUM_W){sum[SUM_W-1]}}, sum};
      wid_sat = (req_width > MAX_WID) ? MAX_WID : req_width;
      if (wid_sat >= MAX_WID) begin
         mask = '1;
      end else begin
         mask = (MAX_FIELD_WIDTH'(1) << wid_sat) - MAX_FIELD_WIDTH'(1);
      end
      field = req_end_marker ? '1 : full[MAX_FIELD_WIDTH-1:0];
      item_data       = field & mask;
      item_ctrl.wid   = wid_sat;
      item_ctrl.flush = req_end_of_block;
   end

endmodule

### sv/bfbp_queue.sv
// two entry item queue between front and back
// depends on bfbp_pkg
module bfbp_queue import bfbp_pkg::*; #(
   parameter int MAX_FIELD_WIDTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [MAX_FIELD_WIDTH-1:0]  push_data,
   input  item_ctrl_type               push_ctrl,
   output logic                        full,
   output logic                        pop_valid,
   output logic [MAX_FIELD_WIDTH-1:0]  pop_data,
   output item_ctrl_type               pop_ctrl,
   input  logic                        pop,
   output logic [QCOUNT_W-1:0]         count
);

   logic [MAX_FIELD_WIDTH-1:0] data_ff [QDEPTH];
   item_ctrl_type              ctrl_ff [QDEPTH];
   logic                       wr_ptr_ff, wr_ptr_in;
   logic                       rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0]        count_ff, count_in;
   logic                       do_push, do_pop;

   always_comb begin
      full      = (count_ff == QCOUNT_W'(QDEPTH));
      pop_valid = (count_ff != '0);
      pop_data  = data_ff[rd_ptr_ff];
      pop_ctrl  = ctrl_ff[rd_ptr_ff];
      count     = count_ff;
      do_push   = push && !full;
      do_pop    = pop && pop_valid;
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
         ctrl_ff[wr_ptr_ff] <= push_ctrl;
      end
   end

endmodule

### sv/bfbp_back.sv
// back end: merges fields with the leftover bits and sends one byte a cycle
// while the held byte is not stalled; depends on bfbp_pkg
module bfbp_back import bfbp_pkg::*; #(
   parameter int MAX_FIELD_WIDTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  logic [MAX_FIELD_WIDTH-1:0]  q_data,
   input  item_ctrl_type               q_ctrl,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [BYTE_BITS-1:0]        rsp_out_byte,
   output logic                        rsp_last,
   output back_status_type             status
);

   localparam int AW = MAX_FIELD_WIDTH + BYTE_BITS - 1;
   localparam int CW = $clog2(MAX_FIELD_WIDTH + BYTE_BITS);
   localparam logic [CW-1:0] BYTE_CNT = CW'(BYTE_BITS);

   logic [AW-1:0]        acc_ff, acc_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 fl_ff, fl_in;
   logic                 valid_ff, valid_in;
   logic [BYTE_BITS-1:0] byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 out_free, has_byte, busy, load, emit, emit_last;

   always_comb begin
      out_free  = !valid_ff || !rsp_stall;
      has_byte  = (cnt_ff >= BYTE_CNT);
      busy      = has_byte || fl_ff;
      load      = !busy && q_valid;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      fl_in     = fl_ff;
      emit      = 1'b0;
      emit_last = 1'b0;
      byte_in   = byte_ff;
      last_in   = last_ff;
      if (load) begin
         acc_in = acc_ff | (AW'(q_data) << cnt_ff[2:0]);
         cnt_in = cnt_ff + CW'(q_ctrl.wid);
         fl_in  = q_ctrl.flush;
      end else if (busy && out_free) begin
         if (has_byte) begin
            emit      = 1'b1;
            emit_last = fl_ff && (cnt_ff == BYTE_CNT);
            acc_in    = acc_ff >> BYTE_BITS;
            cnt_in    = cnt_ff - BYTE_CNT;
            if (emit_last) begin
               fl_in = 1'b0;
            end
         end else begin
            // flush of a part byte, upper bits already zero
            emit      = (cnt_ff != '0);
            emit_last = emit;
            acc_in    = '0;
            cnt_in    = '0;
            fl_in     = 1'b0;
         end
      end
      if (emit) begin
         byte_in = acc_ff[BYTE_BITS-1:0];
         last_in = emit_last;
      end
      valid_in = out_free ? emit : valid_ff;

      q_pop        = load;
      rsp_valid    = valid_ff;
      rsp_out_byte = byte_ff;
      rsp_last     = last_ff;

      status.load           = load;
      status.emit           = emit;
      status.emit_last      = emit_last;
      status.busy           = busy;
      status.flushing       = fl_ff;
      status.leftover_empty = (cnt_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         cnt_ff   <= '0;
         fl_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         fl_ff    <= fl_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule
